/* rtl/core/bbe_pkg.sv */
// Shared constants, types and state codes of the edge-clipped RGB box blur.
// Used by the top module and the divider cell; depends on nothing.
`default_nettype none
package bbe_pkg;
  localparam int MAX_WINDOW = 7;
  localparam int MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int STORE_DEPTH = (MAX_WINDOW - 1) * MAX_WIDTH + MAX_WINDOW;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CFG_DIM_W = 12;
  localparam int CFG_WIN_W = 3;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int K_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int OFF_W = $clog2(MAX_WINDOW + 1);
  localparam int NCH = 3;
  localparam int CH_W = 8;
  localparam int PIX_W = NCH * CH_W;
  localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int CNT_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  typedef struct packed {
    logic valid;
    logic last;
    logic [CNT_W-1:0] cnt;
    logic [NCH-1:0][CNT_W-1:0] rem;
    logic [NCH-1:0][SUM_W-1:0] num;
    logic [NCH-1:0][SUM_W-1:0] quo;
  } div_stage_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_FEED  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;
endpackage
`default_nettype wire

/* rtl/core/rgb_box_blur_edge_clipped_top.sv */
// Edge-clipped RGB box blur: pixel store, window sequencer, divider cell chain.
// Depends on bbe_pkg, bbe_ram and bbe_div_cell.
// A result item passes through the scan of its clipped window in the store, the
// divider cell chain, the result register and the output register. Throughput: one
// item per cycle for items without a result; an item with a result holds the input
// side until its result is registered at the output; the store reads once per cycle.
// Reset clears the input and output frame counters and sets the configuration to 640 x 480 with a 3 x 3 window.
`default_nettype none
module rgb_box_blur_edge_clipped_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [bbe_pkg::PIX_W-1:0]     in_tdata,   // in_red, in_green, in_blue
  input  wire logic                          in_tuser,   // action
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [bbe_pkg::PIX_W-1:0]     out_tdata,  // out_red, out_green, out_blue
  output logic                               out_tlast,  // frame_end
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [bbe_pkg::PADDR_W-1:0]   cfg_paddr,
  input  wire logic [bbe_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic      [bbe_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  localparam int AW = bbe_pkg::ADDR_W;
  localparam int DW = bbe_pkg::CFG_DIM_W;
  localparam int OW = bbe_pkg::OFF_W;
  localparam logic [AW:0] DEPTH_X = (AW+1)'(bbe_pkg::STORE_DEPTH);

  logic [DW-1:0] cfg_width_r, cfg_height_r;
  logic [bbe_pkg::CFG_WIN_W-1:0] cfg_window_r;
  bbe_pkg::state_t state_r, state_nxt;

  logic [bbe_pkg::ROW_W-1:0] in_row_r;
  logic [bbe_pkg::COL_W-1:0] in_col_r;
  logic [bbe_pkg::K_W-1:0] in_k_r;
  logic [AW-1:0] wp_r, out_addr_r;
  logic [bbe_pkg::OROW_W-1:0] out_row_r;
  logic [bbe_pkg::COL_W-1:0] out_col_r;

  logic [OW-1:0] srow_r, scol_r, row_last_r, col_last_r;
  logic [AW-1:0] rowbase_r, addr_r;
  logic rd_vld_r;
  logic [bbe_pkg::NCH-1:0][bbe_pkg::SUM_W-1:0] sum_r;
  logic [bbe_pkg::CNT_W-1:0] cnt_r;
  logic fend_r;
  logic [bbe_pkg::PIX_W-1:0] res_r;
  logic res_last_r;
  logic out_valid_r;
  logic [bbe_pkg::PIX_W-1:0] out_data_r;
  logic out_last_r;

  logic [DW-1:0] w_eff, h_eff;
  logic [OW-1:0] n_eff, up, dn;
  logic [bbe_pkg::K_W-1:0] lag;
  logic cfg_wr, in_acc, in_done, is_flush, emit;
  logic [DW-1:0] r_x, c_x, rem_rows, rem_cols;
  logic [OW-1:0] dr, dc, down_r, down_c;
  logic [AW-1:0] off;
  logic [AW:0] rowbase_calc;
  logic [AW:0] rb_sum, rb_next;
  logic [bbe_pkg::PIX_W-1:0] rd_data;
  logic col_end, row_end;
  bbe_pkg::div_stage_t feed;
  bbe_pkg::div_stage_t chain [bbe_pkg::SUM_W+1];
  logic [bbe_pkg::PIX_W-1:0] rounded;
  logic [bbe_pkg::CNT_W:0] rem2 [bbe_pkg::NCH];
  logic [bbe_pkg::CH_W-1:0] qlo [bbe_pkg::NCH];
  logic round_up [bbe_pkg::NCH];

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[3:2])
      bbe_pkg::REG_WIDTH:  cfg_prdata = {{(bbe_pkg::PDATA_W-DW){1'b0}}, cfg_width_r};
      bbe_pkg::REG_HEIGHT: cfg_prdata = {{(bbe_pkg::PDATA_W-DW){1'b0}}, cfg_height_r};
      bbe_pkg::REG_WINDOW: cfg_prdata = {{(bbe_pkg::PDATA_W-bbe_pkg::CFG_WIN_W){1'b0}},
                                         cfg_window_r};
      default:             cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (cfg_width_r == '0) w_eff = DW'(1);
    else if (cfg_width_r > DW'(bbe_pkg::MAX_WIDTH)) w_eff = DW'(bbe_pkg::MAX_WIDTH);
    else w_eff = cfg_width_r;
    if (cfg_height_r == '0) h_eff = DW'(1);
    else if (cfg_height_r > DW'(bbe_pkg::MAX_HEIGHT)) h_eff = DW'(bbe_pkg::MAX_HEIGHT);
    else h_eff = cfg_height_r;
    if (cfg_window_r == '0) n_eff = OW'(1);
    else if (OW'(cfg_window_r) > OW'(bbe_pkg::MAX_WINDOW)) n_eff = OW'(bbe_pkg::MAX_WINDOW);
    else n_eff = OW'(cfg_window_r);
    up = (n_eff - OW'(1)) >> 1;
    dn = n_eff >> 1;
    lag = bbe_pkg::K_W'(dn) * bbe_pkg::K_W'(w_eff) + bbe_pkg::K_W'(dn);
  end

  assign in_tready = (state_r == bbe_pkg::ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign is_flush = in_tuser;
  assign in_done = in_row_r >= bbe_pkg::ROW_W'(h_eff);
  assign emit = in_acc && (is_flush ? (in_done && (DW'(out_row_r) < h_eff))
                                    : (!in_done && in_k_r >= lag));

  // Clipped window geometry of the next result.
  always_comb begin
    r_x = DW'(out_row_r);
    c_x = DW'(out_col_r);
    dr = (r_x >= DW'(up)) ? up : OW'(r_x);
    dc = (c_x >= DW'(up)) ? up : OW'(c_x);
    rem_rows = h_eff - DW'(1) - r_x;
    rem_cols = w_eff - DW'(1) - c_x;
    down_r = (rem_rows < DW'(dn)) ? OW'(rem_rows) : dn;
    down_c = (rem_cols < DW'(dn)) ? OW'(rem_cols) : dn;
    off = AW'(dr) * AW'(w_eff) + AW'(dc);
    if (out_addr_r >= off) rowbase_calc = {1'b0, out_addr_r} - {1'b0, off};
    else rowbase_calc = {1'b0, out_addr_r} + DEPTH_X - {1'b0, off};
    rb_sum = {1'b0, rowbase_r} + (AW+1)'(w_eff);
    rb_next = (rb_sum >= DEPTH_X) ? rb_sum - DEPTH_X : rb_sum;
  end

  assign col_end = (DW'(out_col_r) == w_eff - DW'(1));
  assign row_end = (DW'(out_row_r) == h_eff - DW'(1));

  bbe_ram #(.WIDTH(bbe_pkg::PIX_W), .DEPTH(bbe_pkg::STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (in_acc && !is_flush && !in_done),
    .waddr (wp_r),
    .wdata (in_tdata),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bbe_pkg::ST_IDLE:  if (emit) state_nxt = bbe_pkg::ST_SCAN;
      bbe_pkg::ST_SCAN:  if (scol_r == col_last_r && srow_r == row_last_r) begin
                           state_nxt = bbe_pkg::ST_DRAIN;
                         end
      bbe_pkg::ST_DRAIN: state_nxt = bbe_pkg::ST_FEED;
      bbe_pkg::ST_FEED:  state_nxt = bbe_pkg::ST_DIV;
      bbe_pkg::ST_DIV:   if (chain[bbe_pkg::SUM_W].valid) state_nxt = bbe_pkg::ST_OUT;
      bbe_pkg::ST_OUT:   if (!out_valid_r || out_tready) state_nxt = bbe_pkg::ST_IDLE;
      default:           state_nxt = bbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbe_pkg::ST_IDLE;
      cfg_width_r <= DW'(640);
      cfg_height_r <= DW'(480);
      cfg_window_r <= bbe_pkg::CFG_WIN_W'(3);
      in_row_r <= '0;
      in_col_r <= '0;
      in_k_r <= '0;
      wp_r <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      out_addr_r <= '0;
      rd_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_vld_r <= (state_r == bbe_pkg::ST_SCAN);
      if (in_acc && !is_flush && !in_done) begin
        wp_r <= (wp_r == AW'(bbe_pkg::STORE_DEPTH - 1)) ? '0 : wp_r + AW'(1);
        in_k_r <= in_k_r + bbe_pkg::K_W'(1);
        if (DW'(in_col_r) == w_eff - DW'(1)) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + bbe_pkg::ROW_W'(1);
        end else begin
          in_col_r <= in_col_r + bbe_pkg::COL_W'(1);
        end
      end
      if (emit) begin
        out_addr_r <= (out_addr_r == AW'(bbe_pkg::STORE_DEPTH - 1)) ? '0
                                                                  : out_addr_r + AW'(1);
        if (col_end) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + bbe_pkg::OROW_W'(1);
        end else begin
          out_col_r <= out_col_r + bbe_pkg::COL_W'(1);
        end
      end
      if ((emit && col_end && row_end) || cfg_wr) begin
        in_row_r <= '0;
        in_col_r <= '0;
        in_k_r <= '0;
        wp_r <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
        out_addr_r <= '0;
      end
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          bbe_pkg::REG_WIDTH:  cfg_width_r <= cfg_pwdata[DW-1:0];
          bbe_pkg::REG_HEIGHT: cfg_height_r <= cfg_pwdata[DW-1:0];
          bbe_pkg::REG_WINDOW: cfg_window_r <= cfg_pwdata[bbe_pkg::CFG_WIN_W-1:0];
          default: ;
        endcase
      end
      if (state_r == bbe_pkg::ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      srow_r <= '0;
      scol_r <= '0;
      row_last_r <= dr + down_r;
      col_last_r <= dc + down_c;
      rowbase_r <= rowbase_calc[AW-1:0];
      addr_r <= rowbase_calc[AW-1:0];
      fend_r <= col_end && row_end;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      if (state_r == bbe_pkg::ST_SCAN) begin
        if (scol_r == col_last_r) begin
          scol_r <= '0;
          srow_r <= srow_r + OW'(1);
          rowbase_r <= rb_next[AW-1:0];
          addr_r <= rb_next[AW-1:0];
        end else begin
          scol_r <= scol_r + OW'(1);
          addr_r <= (addr_r == AW'(bbe_pkg::STORE_DEPTH - 1)) ? '0 : addr_r + AW'(1);
        end
      end
      if (rd_vld_r) begin
        for (int i = 0; i < bbe_pkg::NCH; i++) begin
          sum_r[i] <= sum_r[i] + bbe_pkg::SUM_W'(rd_data[i*bbe_pkg::CH_W +: bbe_pkg::CH_W]);
        end
        cnt_r <= cnt_r + bbe_pkg::CNT_W'(1);
      end
    end
    if (state_r == bbe_pkg::ST_DIV && chain[bbe_pkg::SUM_W].valid) begin
      res_r <= rounded;
      res_last_r <= chain[bbe_pkg::SUM_W].last;
    end
    if (state_r == bbe_pkg::ST_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= res_r;
      out_last_r <= res_last_r;
    end
  end

  always_comb begin
    feed.valid = (state_r == bbe_pkg::ST_FEED);
    feed.last = fend_r;
    feed.cnt = cnt_r;
    feed.rem = '0;
    feed.num = sum_r;
    feed.quo = '0;
  end

  assign chain[0] = feed;

  for (genvar g = 0; g < bbe_pkg::SUM_W; g++) begin : g_cell
    bbe_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  // Round to nearest, ties to even.
  always_comb begin
    for (int i = 0; i < bbe_pkg::NCH; i++) begin
      rem2[i] = {chain[bbe_pkg::SUM_W].rem[i], 1'b0};
      qlo[i] = chain[bbe_pkg::SUM_W].quo[i][bbe_pkg::CH_W-1:0];
      round_up[i] = (rem2[i] > {1'b0, chain[bbe_pkg::SUM_W].cnt}) ||
                    ((rem2[i] == {1'b0, chain[bbe_pkg::SUM_W].cnt}) && qlo[i][0]);
      rounded[i*bbe_pkg::CH_W +: bbe_pkg::CH_W] = qlo[i] + bbe_pkg::CH_W'(round_up[i]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;
endmodule
`default_nettype wire

/* rtl/core/bbe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Self-contained; depends on nothing.
`default_nettype none
module bbe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/bbe_div_cell.sv */
// One restoring-division cell: resolves one quotient bit for all three channels.
// Depends on bbe_pkg for the stage struct and widths.
`default_nettype none
module bbe_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bbe_pkg::div_stage_t d_in,
  output bbe_pkg::div_stage_t     d_out
);
  bbe_pkg::div_stage_t stage_nxt;
  logic [bbe_pkg::CNT_W:0] trial [bbe_pkg::NCH];
  logic                    ge [bbe_pkg::NCH];
  logic [bbe_pkg::CNT_W:0] diff [bbe_pkg::NCH];

  always_comb begin
    stage_nxt = d_in;
    for (int i = 0; i < bbe_pkg::NCH; i++) begin
      trial[i] = {d_in.rem[i], d_in.num[i][bbe_pkg::SUM_W-1]};
      ge[i] = trial[i] >= {1'b0, d_in.cnt};
      diff[i] = trial[i] - {1'b0, d_in.cnt};
      stage_nxt.rem[i] = ge[i] ? diff[i][bbe_pkg::CNT_W-1:0]
                               : trial[i][bbe_pkg::CNT_W-1:0];
      stage_nxt.num[i] = {d_in.num[i][bbe_pkg::SUM_W-2:0], 1'b0};
      stage_nxt.quo[i] = {d_in.quo[i][bbe_pkg::SUM_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out.valid <= 1'b0;
    end else begin
      d_out.valid <= stage_nxt.valid;
    end
    d_out.last <= stage_nxt.last;
    d_out.cnt <= stage_nxt.cnt;
    d_out.rem <= stage_nxt.rem;
    d_out.num <= stage_nxt.num;
    d_out.quo <= stage_nxt.quo;
  end
endmodule
`default_nettype wire
